/* design/bfern_pkg.sv */
// ----------------------------------------------------------------------------
// bfern_pkg
// Shared widths, fixed map coefficients, thresholds, codes and types of the
// fern point generator.
// ----------------------------------------------------------------------------
package bfern_pkg;

    localparam int DATA_W     = 32;  // Q15 point and product width
    localparam int COEF_W     = 22;  // serial multiplier coefficient width
    localparam int FRAC_W     = 15;  // fraction bits
    localparam int DRAW_W     = 31;
    localparam int CFG_COEF_W = 18;
    localparam int SCALE_W    = 21;
    localparam int LANES      = 4;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int OUT_W      = 6 * DATA_W;

    // Draw thresholds that pick the map.
    localparam logic [DRAW_W-1:0] THRESH_MAP1 = 31'd21474835;
    localparam logic [DRAW_W-1:0] THRESH_MAP2 = 31'd1846835936;
    localparam logic [DRAW_W-1:0] THRESH_MAP3 = 31'd1997159792;

    // Fixed Q15 coefficients.
    localparam logic signed [COEF_W-1:0] K_M1_Y  = 22'sd5242;
    localparam logic signed [COEF_W-1:0] K_M2_YY = 22'sd27852;
    localparam logic signed [COEF_W-1:0] K_M3_XX = 22'sd6553;
    localparam logic signed [COEF_W-1:0] K_M3_XY = 22'sd8519;
    localparam logic signed [COEF_W-1:0] K_M3_YX = 22'sd7536;
    localparam logic signed [COEF_W-1:0] K_M3_YY = 22'sd7208;
    localparam logic signed [COEF_W-1:0] K_M4_XX = -22'sd4915;
    localparam logic signed [COEF_W-1:0] K_M4_XY = 22'sd9175;
    localparam logic signed [COEF_W-1:0] K_M4_YX = 22'sd8519;
    localparam logic signed [COEF_W-1:0] K_M4_YY = 22'sd7864;
    localparam logic signed [DATA_W-1:0] K_M3_YC = 32'sd52428;
    localparam logic signed [DATA_W-1:0] K_M4_YC = 32'sd14417;

    // Register reset values.
    localparam logic signed [CFG_COEF_W-1:0] RST_X_FROM_X = 18'sd26869;
    localparam logic signed [CFG_COEF_W-1:0] RST_X_FROM_Y = 18'sd2621;
    localparam logic signed [CFG_COEF_W-1:0] RST_Y_FROM_X = -18'sd2621;
    localparam logic signed [CFG_COEF_W-1:0] RST_Y_ADD    = 18'sd52428;
    localparam logic [SCALE_W-1:0]           RST_SCALE    = 21'd983040;

    typedef enum logic [2:0] {
        REG_X_FROM_X = 3'd0,
        REG_X_FROM_Y = 3'd1,
        REG_Y_FROM_X = 3'd2,
        REG_Y_ADD    = 3'd3,
        REG_SCALE    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CFG_COEF_W-1:0] x_from_x;
        logic signed [CFG_COEF_W-1:0] x_from_y;
        logic signed [CFG_COEF_W-1:0] y_from_x;
        logic signed [CFG_COEF_W-1:0] y_add;
        logic [SCALE_W-1:0]           scale;
    } cfg_t;

    typedef enum logic [1:0] {
        MAP1 = 2'd0,
        MAP2 = 2'd1,
        MAP3 = 2'd2,
        MAP4 = 2'd3
    } map_t;

    typedef enum logic [1:0] {
        RND_NEW   = 2'd0,
        RND_LEFT  = 2'd1,
        RND_RIGHT = 2'd2,
        RND_SCALE = 2'd3
    } round_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOAD = 2'd1,
        ST_WAIT = 2'd2,
        ST_HOLD = 2'd3
    } state_t;

endpackage

/* design/bfern_cfg.sv */
// ----------------------------------------------------------------------------
// bfern_cfg
// APB register file holding the second-map coefficients and the leaf scale.
// ----------------------------------------------------------------------------
module bfern_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfern_pkg::PADDR_W-1:0] paddr,
    input  logic [bfern_pkg::PDATA_W-1:0] pwdata,
    output logic [bfern_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output bfern_pkg::cfg_t              cfg
);
    import bfern_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = cfg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_X_FROM_X: cfg_next.x_from_x = pwdata[CFG_COEF_W-1:0];
                REG_X_FROM_Y: cfg_next.x_from_y = pwdata[CFG_COEF_W-1:0];
                REG_Y_FROM_X: cfg_next.y_from_x = pwdata[CFG_COEF_W-1:0];
                REG_Y_ADD:    cfg_next.y_add    = pwdata[CFG_COEF_W-1:0];
                REG_SCALE:    cfg_next.scale    = pwdata[SCALE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_X_FROM_X: prdata = PDATA_W'(cfg_reg.x_from_x);
            REG_X_FROM_Y: prdata = PDATA_W'(cfg_reg.x_from_y);
            REG_Y_FROM_X: prdata = PDATA_W'(cfg_reg.y_from_x);
            REG_Y_ADD:    prdata = PDATA_W'(cfg_reg.y_add);
            REG_SCALE:    prdata = {{(PDATA_W-SCALE_W){1'b0}}, cfg_reg.scale};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_from_x <= RST_X_FROM_X;
            cfg_reg.x_from_y <= RST_X_FROM_Y;
            cfg_reg.y_from_x <= RST_Y_FROM_X;
            cfg_reg.y_add    <= RST_Y_ADD;
            cfg_reg.scale    <= RST_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/bfern_smul.sv */
// ----------------------------------------------------------------------------
// bfern_smul
// Bit-serial signed Q15 multiplier: one coefficient bit per cycle, LSB first,
// result is the product shifted right by 15 and cut to 32 bits.
// ----------------------------------------------------------------------------
module bfern_smul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [bfern_pkg::COEF_W-1:0] coef,
    input  logic signed [bfern_pkg::DATA_W-1:0] opnd,
    output logic                               done,
    output logic signed [bfern_pkg::DATA_W-1:0] result
);
    import bfern_pkg::*;

    localparam int ACC_W = DATA_W + 2;
    localparam int CNT_W = $clog2(COEF_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(COEF_W - 1);

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [COEF_W-1:0]        lo_reg, lo_next;
    logic [COEF_W-1:0]        coef_reg, coef_next;
    logic signed [DATA_W-1:0] opnd_reg, opnd_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [ACC_W-1:0]  opnd_ext;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  sum;
    logic                     last;
    logic [ACC_W+COEF_W-1:0]  prod;

    assign opnd_ext = $signed({{(ACC_W-DATA_W){opnd_reg[DATA_W-1]}}, opnd_reg});
    assign last     = (cnt_reg == LAST_BIT);

    always_comb
    begin
        // The top coefficient bit carries negative weight.
        if (coef_reg[0])
            addend = last ? -opnd_ext : opnd_ext;
        else
            addend = '0;
        sum = acc_reg + addend;

        acc_next  = acc_reg;
        lo_next   = lo_reg;
        coef_next = coef_reg;
        opnd_next = opnd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            lo_next   = '0;
            coef_next = coef;
            opnd_next = opnd;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = sum >>> 1;
            lo_next   = {sum[0], lo_reg[COEF_W-1:1]};
            coef_next = coef_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        lo_reg   <= lo_next;
        coef_reg <= coef_next;
        opnd_reg <= opnd_next;
    end

    assign prod   = {acc_reg, lo_reg};
    assign result = $signed(prod[FRAC_W+DATA_W-1:FRAC_W]);
    assign done   = done_reg;

endmodule

/* design/barnsley_fern_ifs_point_generator_core.sv */
// ----------------------------------------------------------------------------
// barnsley_fern_ifs_point_generator_core
// Fern point generator: one random draw in, one new point and two scaled
// leaf points out, all in signed Q15.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one request per item: s_tdata[30:0] is the random
// draw. The draw picks one of four affine maps, which moves the stored point.
// The master stream returns one request per item carrying the new point and
// the left and right leaf points (the third and fourth maps of the new point,
// scaled by the scale register).
// The work runs in four rounds on four bit-serial multipliers: the new point,
// the left leaf, the right leaf and the scaling. Each round has a start state
// (ST_LOAD), then the multipliers work through the 22 coefficient bits, LSB
// first, and the wait state (ST_WAIT) collects the products once every lane
// is done. The hold state loads the result into the output register; only
// then, in the idle state, is a new draw taken.
// While the result waits in the output register the block keeps its place;
// a stalled receiver delays only the end of the following item, which then
// waits in the hold state with s_tready low until the register frees up.
// Reset clears the stored point to zero, restores the register defaults and
// drops m_tvalid. Registers are to be written over APB only while idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module barnsley_fern_ifs_point_generator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [30:0] random_draw
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] left_leaf_x,
    // [127:96] left_leaf_y, [159:128] right_leaf_x, [191:160] right_leaf_y
    output logic [bfern_pkg::OUT_W-1:0]   m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfern_pkg::PADDR_W-1:0] paddr,
    input  logic [bfern_pkg::PDATA_W-1:0] pwdata,
    output logic [bfern_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import bfern_pkg::*;

    cfg_t                     cfg;
    state_t                   state_reg, state_next;
    round_t                   round_reg, round_next;
    map_t                     map_reg, map_next;
    map_t                     map_sel;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic signed [DATA_W-1:0] cur_x_reg, cur_x_next;
    logic signed [DATA_W-1:0] cur_y_reg, cur_y_next;
    logic signed [DATA_W-1:0] leaf_reg [LANES];
    logic [OUT_W-1:0]         out_reg;
    logic [DRAW_W-1:0]        draw;
    logic                     accept;
    logic                     start;
    logic                     capture;
    logic                     out_load;
    logic                     all_done;
    logic [LANES-1:0]         lane_done;
    logic signed [COEF_W-1:0] coef [LANES];
    logic signed [DATA_W-1:0] opnd [LANES];
    logic signed [DATA_W-1:0] prod [LANES];
    logic signed [DATA_W-1:0] k_y;
    logic                     sub_x;
    logic signed [DATA_W-1:0] comb_x;
    logic signed [DATA_W-1:0] comb_y;
    logic signed [COEF_W-1:0] scale_coef;

    bfern_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Four serial multiplier lanes share each round.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bfern_smul u_smul (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (start),
            .coef   (coef[i]),
            .opnd   (opnd[i]),
            .done   (lane_done[i]),
            .result (prod[i])
        );
    end

    assign all_done = &lane_done;
    assign draw     = s_tdata[DRAW_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        priority if (draw < THRESH_MAP1)
            map_sel = MAP1;
        else if (draw < THRESH_MAP2)
            map_sel = MAP2;
        else if (draw < THRESH_MAP3)
            map_sel = MAP3;
        else
            map_sel = MAP4;
    end

    assign scale_coef = $signed({{(COEF_W-SCALE_W){1'b0}}, cfg.scale});

    // Coefficients and operands of the current round. Lanes 0 and 1 build x,
    // lanes 2 and 3 build y; in the scaling round every lane stands alone.
    always_comb
    begin
        coef[0] = '0;
        coef[1] = '0;
        coef[2] = '0;
        coef[3] = '0;
        k_y     = '0;
        sub_x   = 1'b0;
        opnd[0] = cur_x_reg;
        opnd[1] = cur_y_reg;
        opnd[2] = cur_x_reg;
        opnd[3] = cur_y_reg;
        unique case (round_reg)
            RND_NEW:
            begin
                unique case (map_reg)
                    MAP1:
                    begin
                        coef[3] = K_M1_Y;
                    end
                    MAP2:
                    begin
                        coef[0] = COEF_W'(cfg.x_from_x);
                        coef[1] = COEF_W'(cfg.x_from_y);
                        coef[2] = COEF_W'(cfg.y_from_x);
                        coef[3] = K_M2_YY;
                        k_y     = DATA_W'(cfg.y_add);
                    end
                    MAP3:
                    begin
                        coef[0] = K_M3_XX;
                        coef[1] = K_M3_XY;
                        coef[2] = K_M3_YX;
                        coef[3] = K_M3_YY;
                        k_y     = K_M3_YC;
                        sub_x   = 1'b1;
                    end
                    MAP4:
                    begin
                        coef[0] = K_M4_XX;
                        coef[1] = K_M4_XY;
                        coef[2] = K_M4_YX;
                        coef[3] = K_M4_YY;
                        k_y     = K_M4_YC;
                    end
                endcase
            end
            RND_LEFT:
            begin
                coef[0] = K_M3_XX;
                coef[1] = K_M3_XY;
                coef[2] = K_M3_YX;
                coef[3] = K_M3_YY;
                k_y     = K_M3_YC;
                sub_x   = 1'b1;
            end
            RND_RIGHT:
            begin
                coef[0] = K_M4_XX;
                coef[1] = K_M4_XY;
                coef[2] = K_M4_YX;
                coef[3] = K_M4_YY;
                k_y     = K_M4_YC;
            end
            RND_SCALE:
            begin
                coef[0] = scale_coef;
                coef[1] = scale_coef;
                coef[2] = scale_coef;
                coef[3] = scale_coef;
                opnd[0] = leaf_reg[0];
                opnd[1] = leaf_reg[1];
                opnd[2] = leaf_reg[2];
                opnd[3] = leaf_reg[3];
            end
        endcase
    end

    // Each product is rounded on its own before the sum, so the subtraction
    // of the third map negates the product rather than the coefficient.
    assign comb_x = prod[0] + (sub_x ? -prod[1] : prod[1]);
    assign comb_y = prod[2] + prod[3] + k_y;

    // Sequencer: start a round, wait for the lanes, collect, move on.
    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        map_next      = map_reg;
        start         = 1'b0;
        capture       = 1'b0;
        out_load      = 1'b0;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    map_next   = map_sel;
                    round_next = RND_NEW;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                start      = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (all_done)
                begin
                    capture = 1'b1;
                    if (round_reg == RND_NEW)
                    begin
                        cur_x_next = comb_x;
                        cur_y_next = comb_y;
                    end
                    if (round_reg == RND_SCALE)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        round_next = round_t'(round_reg + 1'b1);
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= RND_NEW;
            map_reg      <= MAP1;
            m_tvalid_reg <= 1'b0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            map_reg      <= map_next;
            m_tvalid_reg <= m_tvalid_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            unique case (round_reg)
                RND_NEW:
                begin
                    leaf_reg <= leaf_reg;
                end
                RND_LEFT:
                begin
                    leaf_reg[0] <= comb_x;
                    leaf_reg[1] <= comb_y;
                end
                RND_RIGHT:
                begin
                    leaf_reg[2] <= comb_x;
                    leaf_reg[3] <= comb_y;
                end
                RND_SCALE:
                begin
                    leaf_reg[0] <= prod[0];
                    leaf_reg[1] <= prod[1];
                    leaf_reg[2] <= prod[2];
                    leaf_reg[3] <= prod[3];
                end
            endcase
        end
        if (out_load)
        begin
            out_reg <= {leaf_reg[3], leaf_reg[2], leaf_reg[1], leaf_reg[0],
                        cur_y_reg, cur_x_reg};
        end
    end

endmodule

/* design/bfern_chk.sv */
// ----------------------------------------------------------------------------
// bfern_chk
// Port-level checks of the fern point generator, bound to the top level.
// ----------------------------------------------------------------------------
module bfern_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bfern_pkg::OUT_W-1:0]   m_tdata,
    input logic                         pready
);

    // A result held against a stalled receiver keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Items are worked one at a time: no request in the cycle after one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in consecutive cycles");

    // A new result never shows up right after a draw is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result offered too soon after a draw");

    // A result is offered only from the hold state, where input is closed.
    a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result offered while input was open");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind barnsley_fern_ifs_point_generator_core bfern_chk u_bfern_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

/* tb/tb_barnsley_fern_ifs_point_generator_core.sv */
// ----------------------------------------------------------------------------
// tb_barnsley_fern_ifs_point_generator_core
// Self-checking bench for the fern point generator. A queue of random draws
// is streamed into the block in bursts, and an independent Q15 predictor keeps
// its own copy of the stored point and the map registers. Every result request
// is checked field by field against the oldest predicted point, across several
// register settings that include both extremes.
// ----------------------------------------------------------------------------
module tb_barnsley_fern_ifs_point_generator_core;

    timeunit 1ns;
    timeprecision 1ps;

    import bfern_pkg::*;

    // The run is stopped as a failure if it is still going after this many cycles.
    localparam int LIMIT_CYCLES  = 1_000_000;
    // Cycles to let pass after the last result.
    localparam int SETTLE_CYCLES = 120;
    // The receiver's long hold-off, and the result count at which it begins.
    localparam int HOLD_CYCLES   = 1500;
    localparam int HOLD_AFTER    = 300;
    localparam int MAX_REPORTS   = 10;

    // Draw thresholds that pick the map.
    localparam logic [30:0] TH_MAP1 = 31'd21474835;
    localparam logic [30:0] TH_MAP2 = 31'd1846835936;
    localparam logic [30:0] TH_MAP3 = 31'd1997159792;

    // Fixed Q15 coefficients of the four maps, truncated toward zero.
    localparam logic signed [63:0] C1_YY = 5242;
    localparam logic signed [63:0] C2_YY = 27852;
    localparam logic signed [63:0] C3_XX = 6553;
    localparam logic signed [63:0] C3_XY = 8519;
    localparam logic signed [63:0] C3_YX = 7536;
    localparam logic signed [63:0] C3_YY = 7208;
    localparam logic [31:0]        C3_YC = 32'd52428;
    localparam logic signed [63:0] C4_XX = -4915;
    localparam logic signed [63:0] C4_XY = 9175;
    localparam logic signed [63:0] C4_YX = 8519;
    localparam logic signed [63:0] C4_YY = 7864;
    localparam logic [31:0]        C4_YC = 32'd14417;

    // Stall patterns of the receiver.
    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,
        RX_HALF   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_MOSTLY = 2'd3
    } rx_mode_t;

    // One result, packed the way the master stream carries it:
    // point_x lowest, then point_y, left_leaf_x, left_leaf_y, right_leaf_x,
    // right_leaf_y.
    typedef logic [OUT_W-1:0] fern_result_t;

    logic                 clk;
    logic                 rst_n   = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;     // [30:0] random_draw
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // point_x .. right_leaf_y, 32 bits each
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    barnsley_fern_ifs_point_generator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor copy of the map registers and of the stored point.
    logic signed [17:0] cfg_x_from_x = 18'sd26869;
    logic signed [17:0] cfg_x_from_y = 18'sd2621;
    logic signed [17:0] cfg_y_from_x = -18'sd2621;
    logic signed [17:0] cfg_y_add    = 18'sd52428;
    logic [20:0]        cfg_scale    = 21'd983040;
    logic [31:0]        fern_x = '0;
    logic [31:0]        fern_y = '0;

    // Draws waiting to be sent, and predicted points waiting to come back.
    logic [30:0]  draw_q[$];
    fern_result_t expected_points[$];

    int fail_cnt     = 0;
    int points_seen  = 0;
    int reg_writes   = 0;
    int in_stalls    = 0;
    int cycle_cnt    = 0;
    int map_hits[4]  = '{0, 0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Q15 product: the full signed product, bits 46 down to 15. The low word of
    // the shifted product is the same whether the shift is logical or arithmetic.
    function automatic logic [31:0] q15_mul(input logic signed [63:0] coef,
                                            input logic [31:0] value);
        logic signed [63:0] prod;
        prod = coef * $signed(value);
        return prod[46:15];
    endfunction

    function automatic void apply_map3(input logic [31:0] x, input logic [31:0] y,
                                       output logic [31:0] nx, output logic [31:0] ny);
        nx = q15_mul(C3_XX, x) - q15_mul(C3_XY, y);
        ny = q15_mul(C3_YX, x) + q15_mul(C3_YY, y) + C3_YC;
    endfunction

    function automatic void apply_map4(input logic [31:0] x, input logic [31:0] y,
                                       output logic [31:0] nx, output logic [31:0] ny);
        nx = q15_mul(C4_XX, x) + q15_mul(C4_XY, y);
        ny = q15_mul(C4_YX, x) + q15_mul(C4_YY, y) + C4_YC;
    endfunction

    function automatic map_t pick_map(input logic [30:0] draw);
        if (draw < TH_MAP1)
            return MAP1;
        else if (draw < TH_MAP2)
            return MAP2;
        else if (draw < TH_MAP3)
            return MAP3;
        return MAP4;
    endfunction

    // Moves the stored point by the map that the draw selects and returns the
    // new point with its two scaled leaf points.
    function automatic fern_result_t advance_fern(input logic [30:0] draw);
        map_t        which;
        logic [31:0] nx, ny, lx, ly, rx, ry;
        which = pick_map(draw);
        map_hits[int'(which)]++;
        case (which)
            MAP1:
            begin
                nx = '0;
                ny = q15_mul(C1_YY, fern_y);
            end
            MAP2:
            begin
                nx = q15_mul(cfg_x_from_x, fern_x) + q15_mul(cfg_x_from_y, fern_y);
                ny = q15_mul(cfg_y_from_x, fern_x) + q15_mul(C2_YY, fern_y)
                   + {{14{cfg_y_add[17]}}, cfg_y_add};
            end
            MAP3:    apply_map3(fern_x, fern_y, nx, ny);
            default: apply_map4(fern_x, fern_y, nx, ny);
        endcase
        apply_map3(nx, ny, lx, ly);
        apply_map4(nx, ny, rx, ry);
        fern_x = nx;
        fern_y = ny;
        return {q15_mul(cfg_scale, ry), q15_mul(cfg_scale, rx),
                q15_mul(cfg_scale, ly), q15_mul(cfg_scale, lx), ny, nx};
    endfunction

    // ------------------------------------------------------------------------
    // Input side: bursts of requests with random gaps between them. A request
    // that is offered stays offered until the block takes it, and the
    // prediction is made at the edge where it is taken.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin : input_driver
        logic offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            offer = 1'b0;
            if (s_tvalid && s_tready)
            begin
                expected_points.push_back(advance_fern(draw_q[0]));
                draw_q.pop_front();
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    // Mostly short gaps; now and then one long enough to land
                    // anywhere inside the block's multi-round computation.
                    if ($urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(20, 160);
                    else
                        gap_left = $urandom_range(0, 3);
                end
            end
            if (s_tvalid && !s_tready)
            begin
                offer = 1'b1;
                in_stalls++;
            end
            else if (gap_left > 0)
                gap_left--;
            else if (draw_q.size() != 0)
                offer = 1'b1;
            s_tvalid <= offer;
            if (offer)
                s_tdata <= {1'b0, draw_q[0]};
        end
    end

    // ------------------------------------------------------------------------
    // Output side: the receiver switches between stall patterns, and once it
    // holds off for a long stretch so that the block backs up into its input.
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    int       rx_taken  = 0;
    logic     hold_done = 1'b0;

    always @(posedge clk)
    begin : output_receiver
        logic ready;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                rx_taken++;
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 600);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            else if (!hold_done && rx_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                ready     = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:   ready = 1'b1;
                    RX_HALF:   ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: ready = ($urandom_range(0, 7) == 0);
                    default:   ready = ($urandom_range(0, 3) != 0);
                endcase
            end
            m_tready <= ready;
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each result request is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    function automatic string field_name(input int k);
        case (k)
            0:       return "point_x";
            1:       return "point_y";
            2:       return "left_leaf_x";
            3:       return "left_leaf_y";
            4:       return "right_leaf_x";
            default: return "right_leaf_y";
        endcase
    endfunction

    always @(posedge clk)
    begin : result_checker
        fern_result_t want;
        logic         bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            points_seen++;
            if (expected_points.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("[%0t] result %0d arrived with no point predicted: %h",
                             $realtime, points_seen, m_tdata);
            end
            else
            begin
                want = expected_points.pop_front();
                bad  = 1'b0;
                for (int k = 0; k < 6; k++)
                begin
                    if (m_tdata[k*32 +: 32] !== want[k*32 +: 32])
                    begin
                        if (!bad)
                            fail_cnt++;
                        bad = 1'b1;
                        if (fail_cnt <= MAX_REPORTS)
                            $display("[%0t] result %0d %s: expected %h, got %h",
                                     $realtime, points_seen, field_name(k),
                                     want[k*32 +: 32], m_tdata[k*32 +: 32]);
                    end
                end
            end
        end
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Run stopped after %0d cycles with %0d draws unsent, %0d points due.",
                     cycle_cnt, draw_q.size(), expected_points.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Register access and stimulus
    // ------------------------------------------------------------------------

    // Sets random bits above the register width; the block must ignore them.
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
        logic [31:0] mask;
        mask = (32'h1 << width) - 32'h1;
        return ($urandom() & ~mask) | (value & mask);
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_X_FROM_X: cfg_x_from_x = value[17:0];
            REG_X_FROM_Y: cfg_x_from_y = value[17:0];
            REG_Y_FROM_X: cfg_y_from_x = value[17:0];
            REG_Y_ADD:    cfg_y_add    = value[17:0];
            default:      cfg_scale    = value[20:0];
        endcase
        reg_writes++;
    endtask

    task automatic load_settings(input logic [31:0] x_from_x, input logic [31:0] x_from_y,
                                 input logic [31:0] y_from_x, input logic [31:0] y_add,
                                 input logic [31:0] scale);
        write_reg(REG_X_FROM_X, with_junk(x_from_x, CFG_COEF_W));
        write_reg(REG_X_FROM_Y, with_junk(x_from_y, CFG_COEF_W));
        write_reg(REG_Y_FROM_X, with_junk(y_from_x, CFG_COEF_W));
        write_reg(REG_Y_ADD,    with_junk(y_add, CFG_COEF_W));
        write_reg(REG_SCALE,    with_junk(scale, SCALE_W));
    endtask

    // Returns once every queued draw has been taken and every predicted point
    // has come back, then lets the block settle before registers change.
    task automatic wait_drained();
        @(posedge clk);
        while (draw_q.size() != 0 || expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Draws are spread over the whole range, with extra weight on the rare
    // first map, on the third map and on the values right around each threshold.
    function automatic logic [30:0] random_draw();
        logic [30:0] base;
        case ($urandom_range(0, 9))
            0: return 31'($urandom_range(0, TH_MAP1 - 1));
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       base = TH_MAP1;
                    1:       base = TH_MAP2;
                    default: base = TH_MAP3;
                endcase
                return base - 31'd4 + 31'($urandom_range(0, 7));
            end
            2: return 31'($urandom_range(TH_MAP2, TH_MAP3 - 1));
            default: return 31'($urandom());
        endcase
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            draw_q.push_back(random_draw());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings. Directed draws first: the field extremes, both sides
        // of each threshold, and alternating bit patterns.
        draw_q.push_back(31'd0);
        draw_q.push_back(31'd1);
        draw_q.push_back(TH_MAP1 - 31'd1);
        draw_q.push_back(TH_MAP1);
        draw_q.push_back(TH_MAP1 + 31'd1);
        draw_q.push_back(TH_MAP2 - 31'd1);
        draw_q.push_back(TH_MAP2);
        draw_q.push_back(TH_MAP3 - 31'd1);
        draw_q.push_back(TH_MAP3);
        draw_q.push_back(31'h7FFF_FFFF);
        draw_q.push_back(31'h5555_5555);
        draw_q.push_back(31'h2AAA_AAAA);
        draw_q.push_back(31'h4000_0000);
        draw_q.push_back(31'h0000_0000);
        draw_q.push_back(TH_MAP3 + 31'd7);
        draw_q.push_back(31'd12345);
        queue_random(250);
        wait_drained();

        // Random settings; the receiver's long hold-off falls in this phase.
        load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        queue_random(200);
        wait_drained();

        // Largest coefficients and scale: the point grows until it wraps.
        load_settings(32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF, 32'h0001_FFFF,
                      32'h001F_FFFF);
        queue_random(150);
        wait_drained();

        // Most negative coefficients and a zero scale.
        load_settings(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                      32'h0000_0000);
        queue_random(150);
        wait_drained();

        load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        queue_random(250);
        wait_drained();

        // Back to the reset values, written explicitly this time.
        load_settings(32'd26869, 32'd2621, -32'sd2621, 32'd52428, 32'd983040);
        queue_random(250);
        wait_drained();

        fail_cnt += expected_points.size();
        $display("Checked %0d points (maps 1-4: %0d/%0d/%0d/%0d) over six register settings.",
                 points_seen, map_hits[0], map_hits[1], map_hits[2], map_hits[3]);
        $display("%0d register writes; input held back for %0d cycles; %0d failures.",
                 reg_writes, in_stalls, fail_cnt);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
